FILE: rtl/rlcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcf_pkg: shared types and constants of the random LED colour fade engine
// Holds the store entry layout, the pixel colour record and field widths.
// ----------------------------------------------------------------------------
package rlcf_pkg;

  localparam int LEDS_DEFAULT = 32;
  localparam int ACC_W        = 32;
  localparam int LFSR_W       = 9;
  localparam int PIXEL_W      = 5;
  localparam int CH_W         = 8;
  localparam int BAND_W       = 3;
  localparam int BANDS        = 7;
  localparam int SHADE_SHIFT  = 6;
  localparam int SHADE_W      = 16;

  localparam logic [LFSR_W-1:0] SEED_RESET     = 9'h001;
  localparam logic [LFSR_W-1:0] TWINKLE_COLOUR = 9'h0DF;
  localparam logic [CH_W-1:0]   CH_FULL        = 8'hFF;

  // One LED entry of the state memory
  typedef struct packed {
    logic [ACC_W-1:0] step;
    logic [ACC_W-1:0] acc;
  } entry_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

endpackage

FILE: rtl/rlcf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcf_store: per-LED accumulator and fade step memory
// One write and one registered read port; an entry with its valid bit clear
// reads as zero, so clearing the valid bits empties the whole store.
// ----------------------------------------------------------------------------
module rlcf_store #(
  parameter int DEPTH  = rlcf_pkg::LEDS_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output rlcf_pkg::entry_t    rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  rlcf_pkg::entry_t    wr_data
);
  import rlcf_pkg::*;

  entry_t             mem [DEPTH];
  entry_t             rd_q;
  logic               rd_vld;
  logic [DEPTH-1:0]   vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (clear) begin
        vld <= '0;
      end else if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = rd_vld ? rd_q : '0;

`ifndef ASSERT_OFF
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en && rd_addr == wr_addr))
    else $error("store read and write hit the same entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clear |=> vld == '0)
    else $error("store not empty after clear");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (!rd_en || int'(rd_addr) < DEPTH) && (!wr_en || int'(wr_addr) < DEPTH))
    else $error("store address beyond depth");
`endif

endmodule

FILE: rtl/rlcf_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcf_shade: hue band shade generator
// Maps a band and a 16-bit shade index to an RGB value, wrapped to 8 bits.
// ----------------------------------------------------------------------------
module rlcf_shade (
  input  logic [rlcf_pkg::BAND_W-1:0]  band,
  input  logic [rlcf_pkg::SHADE_W-1:0] sidx,
  output rlcf_pkg::rgb_t               colour
);
  import rlcf_pkg::*;

  logic               lo;
  logic signed [10:0] lb, inv, rr, gg, bb;

  always_comb begin
    lo  = (sidx[15:8] == 8'd0);
    lb  = 11'(sidx[7:0]);
    inv = 11'sd255 - lb;
    rr  = '0;
    gg  = '0;
    bb  = '0;
    unique case (band)
      3'd0: begin
        rr = 11'sd255;
        if (lo) bb = inv >>> 1;
        else    gg = lb >>> 2;
      end
      3'd1: begin
        rr = 11'sd255;
        if (lo) gg = 11'sd32 - (inv >>> 3);
        else    gg = 11'sd32 + (lb >>> 1);
      end
      3'd2: begin
        rr = 11'sd255;
        if (lo) begin
          gg = 11'sd127 - (inv >>> 4);
        end else begin
          gg = 11'sd127 + lb;
          if (gg > 11'sd255) begin
            rr = 11'sd510 - gg;
            gg = 11'sd255;
          end
        end
      end
      3'd3: begin
        gg = 11'sd255;
        if (lo) begin
          rr = inv;
        end else begin
          bb = lb <<< 1;
          if (bb > 11'sd255) begin
            gg = 11'sd510 - bb;
            bb = 11'sd255;
          end
        end
      end
      3'd4: begin
        bb = 11'sd255;
        if (lo) begin
          gg = inv <<< 1;
          if (gg > 11'sd255) begin
            bb = 11'sd510 - gg;
            gg = 11'sd255;
          end
        end else begin
          rr = lb >>> 2;
        end
      end
      3'd5: begin
        bb = 11'sd255;
        if (lo) begin
          rr = 11'sd40 - (inv >>> 2);
        end else begin
          rr = 11'sd40 + (lb >>> 1);
          if (rr > 11'sd255) begin
            bb = 11'sd510 - rr;
            rr = 11'sd255;
          end
        end
      end
      default: begin
        rr = 11'sd255;
        if (lo) begin
          bb = 11'sd80 + (inv >>> 1);
          if (bb > 11'sd255) begin
            rr = 11'sd510 - bb;
            bb = 11'sd255;
          end
        end else begin
          bb = 11'sd80 - (lb >>> 1);
        end
      end
    endcase
    colour.r = rr[CH_W-1:0];
    colour.g = gg[CH_W-1:0];
    colour.b = bb[CH_W-1:0];
  end

endmodule

FILE: rtl/random_led_colour_fade_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_led_colour_fade_engine_core: random colour fade engine for an LED strip
// Per frame tick, emits one RGB item per LED plus an optional white twinkle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, payload restart): one item is one frame
//   tick. restart = 1 empties the accumulator store, returns the change pointer
//   to LED 0 and reloads the LFSR from seed stepped once, before the frame.
//   Output channel (out_valid / out_stall): LEDS items per frame in LED order,
//   then a white item for LED 0 when the drawn target is 0xDF; last marks the
//   final item of the frame.
//   Config channel (cfg_valid / cfg_ready, payload seed): always ready; write
//   only while idle. The seed only takes effect at the next restart.
// Timing:
//   The per-LED state sits in one memory with a registered read. Each LED
//   walks read, step update, then add/write-back with shade into the output
//   register, one stage a cycle while the output is not stalled. The next
//   tick is taken only once every LED and any twinkle item have left the
//   stages. A stalled output freezes the whole walk; the next tick may be
//   accepted while the final item still waits.
// Reset: synchronous; store empty, seed 1, LFSR 2, target and pointer zero.
// ----------------------------------------------------------------------------
module random_led_colour_fade_engine_core #(
  parameter int LEDS = rlcf_pkg::LEDS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rlcf_pkg::LFSR_W-1:0]   seed,
  // frame ticks
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          restart,
  // pixel items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rlcf_pkg::PIXEL_W-1:0]  pixel,
  output logic [rlcf_pkg::CH_W-1:0]     red,
  output logic [rlcf_pkg::CH_W-1:0]     green,
  output logic [rlcf_pkg::CH_W-1:0]     blue,
  output logic                          last
);
  import rlcf_pkg::*;

  localparam int IDX_W = $clog2(LEDS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(LEDS - 1);
  localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BANDS - 1);

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] r);
    return {r[7:0], r[8] ^ r[4]};
  endfunction

  // architectural state
  logic [LFSR_W-1:0] seed_q;
  logic [LFSR_W-1:0] lfsr;
  logic [LFSR_W-1:0] target;
  logic [IDX_W-1:0]  pointer;

  // issue stage
  logic              issue_active;
  logic [IDX_W-1:0]  idx;
  logic [BAND_W-1:0] band;

  // read-data stage
  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic [BAND_W-1:0] s1_band;
  entry_t            rd_data;

  // add / write-back stage
  logic              s2_valid;
  logic [IDX_W-1:0]  s2_idx;
  logic [BAND_W-1:0] s2_band;
  logic [ACC_W-1:0]  s2_acc;
  logic [ACC_W-1:0]  s2_step;

  logic              twk_pending;
  logic              adv;
  logic              in_accept;
  logic              hit;
  logic [LFSR_W-1:0] lfsr_drawn;
  logic [ACC_W-1:0]  shifted;
  logic [ACC_W-1:0]  step1;
  logic [ACC_W-1:0]  acc_new;
  logic              wr_en;
  entry_t            wr_data;
  rgb_t              colour;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = issue_active || s1_valid || s2_valid || twk_pending;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_q <= SEED_RESET;
    end else if (cfg_valid) begin
      seed_q <= seed;
    end
  end

  // Issue stage walks the LED index, one memory read per cycle unless the output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_active <= 1'b0;
    end else if (in_accept) begin
      issue_active <= 1'b1;
    end else if (adv && issue_active && idx == LAST_IDX) begin
      issue_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      idx  <= '0;
      band <= '0;
    end else if (adv && issue_active) begin
      idx  <= idx + 1'b1;
      band <= (band == LAST_BAND) ? '0 : band + 1'b1;
    end
  end

  rlcf_store #(
    .DEPTH  (LEDS),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (in_accept && restart),
    .rd_en   (adv && issue_active),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s2_idx),
    .wr_data (wr_data)
  );

  // Read-data stage: the LED under the pointer draws a new target and step
  assign hit        = s1_valid && s1_idx == pointer;
  assign lfsr_drawn = lfsr_next(lfsr);
  assign shifted    = ACC_W'($signed(rd_data.acc) >>> SHADE_SHIFT);
  assign step1      = hit ? (ACC_W'(lfsr_drawn) - shifted) : rd_data.step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue_active;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx  <= idx;
      s1_band <= band;
      s2_idx  <= s1_idx;
      s2_band <= s1_band;
      s2_acc  <= rd_data.acc;
      s2_step <= step1;
    end
  end

  // LFSR, target and pointer; restart only lands while the walk is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr    <= lfsr_next(SEED_RESET);
      target  <= '0;
      pointer <= '0;
    end else if (in_accept && restart) begin
      lfsr    <= lfsr_next(seed_q);
      pointer <= '0;
    end else if (adv) begin
      if (hit) begin
        lfsr   <= lfsr_drawn;
        target <= lfsr_drawn;
      end
      // advance the pointer once the frame's last LED has passed the compare
      if (s1_valid && s1_idx == LAST_IDX) begin
        pointer <= (pointer == LAST_IDX) ? '0 : pointer + 1'b1;
      end
    end
  end

  // Add / write-back stage
  assign acc_new      = s2_acc + s2_step;
  assign wr_en        = adv && s2_valid;
  assign wr_data.step = s2_step;
  assign wr_data.acc  = acc_new;

  rlcf_shade u_shade (
    .band   (s2_band),
    .sidx   (acc_new[SHADE_SHIFT +: SHADE_W]),
    .colour (colour)
  );

  // Output register; the twinkle item follows the last LED when the target hits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      twk_pending <= 1'b0;
    end else if (adv) begin
      if (twk_pending) begin
        out_valid   <= 1'b1;
        twk_pending <= 1'b0;
      end else begin
        out_valid   <= s2_valid;
        twk_pending <= s2_valid && s2_idx == LAST_IDX && target == TWINKLE_COLOUR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (twk_pending) begin
        pixel <= '0;
        red   <= CH_FULL;
        green <= CH_FULL;
        blue  <= CH_FULL;
        last  <= 1'b1;
      end else begin
        pixel <= PIXEL_W'(s2_idx);
        red   <= colour.r;
        green <= colour.g;
        blue  <= colour.b;
        last  <= s2_idx == LAST_IDX && target != TWINKLE_COLOUR;
      end
    end
  end

`ifndef ASSERT_OFF
  a_twinkle_alone: assert property (@(posedge clk) disable iff (rst)
    twk_pending |-> (!issue_active && !s1_valid && !s2_valid))
    else $error("twinkle item overlaps the LED walk");

  a_single_draw: assert property (@(posedge clk) disable iff (rst)
    (adv && hit) |=> (pointer != s1_idx || !s1_valid))
    else $error("change pointer matched twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable({pixel, red, green, blue, last})))
    else $error("stalled output item changed");
`endif

endmodule
